// File: hw/rtl/rc4_pkg.sv
// Shared types and constants for the RC4 stream cipher block.
`default_nettype none

package rc4_pkg;

   // Permutation table geometry
   localparam int PERM_SIZE = 256;
   localparam int PERM_AW   = 8;

   // Shortest key that runs the key schedule (40 bits)
   localparam int MIN_KEY_BYTES = 5;

   // Result status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_SHORT_KEY = 2'd1;
   localparam logic [1:0] STATUS_NO_KEY    = 2'd2;

   // Item mode codes
   localparam logic MODE_KEY  = 1'b0;
   localparam logic MODE_DATA = 1'b1;

   typedef struct packed {
      logic       mode;
      logic [7:0] data_byte;
      logic       last;
   } req_item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] status;
   } rsp_item_type;

   // Port controls for the permutation RAM
   typedef struct packed {
      logic               we;
      logic [PERM_AW-1:0] waddr;
      logic [7:0]         wdata;
      logic [PERM_AW-1:0] raddr;
   } perm_ctl_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_KEY,
      ST_INIT,
      ST_KS_RD,
      ST_KS_ACC,
      ST_KS_SW1,
      ST_KS_SW2,
      ST_DT_RD1,
      ST_DT_J,
      ST_DT_W1,
      ST_DT_W2,
      ST_DT_RD3,
      ST_DT_OUT,
      ST_EMIT
   } rc4_state_type;

endpackage

`default_nettype wire

// File: hw/rtl/rc4_stream_cipher.sv
// Top level of the RC4 stream cipher: handshakes, result register and RAMs.
`default_nettype none

// RC4 byte cipher. Key bytes (mode 0) are collected one per item; the item
// flagged last closes the key and yields one status item (short key below
// five bytes, else OK after the key schedule). Once a key is set, data bytes
// (mode 1) each yield the byte XOR the next keystream byte; before that they
// yield a no-key status item. One item is processed at a time; all work runs
// through a single permutation RAM with one read and one write port. The key
// schedule first fills the table with its identity, then runs one swap step
// per entry. A finished item waits in an output register, so the next item
// is accepted while the result is still stalled.
module rc4_stream_cipher import rc4_pkg::*; #(
   parameter int KEY_STORE_DEPTH = 256
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_item_type req_item,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_item_type      rsp_item
);

   localparam int KW = $clog2(KEY_STORE_DEPTH);

   logic               busy;
   logic               start;
   logic               out_free;
   logic               res_valid;
   rsp_item_type       res_item;
   perm_ctl_type       perm_ctl;
   logic [7:0]         perm_rdata;
   logic               key_we;
   logic [KW-1:0]      key_waddr;
   logic [7:0]         key_wdata;
   logic [KW-1:0]      key_raddr;
   logic [7:0]         key_rdata;

   logic               rsp_valid_ff, rsp_valid_in;
   rsp_item_type       rsp_item_ff, rsp_item_in;

   // Input handshake
   assign req_stall = busy;
   assign start     = req_valid & ~busy;
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;

   rc4_core #(
      .KEY_STORE_DEPTH(KEY_STORE_DEPTH)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .item       (req_item),
      .out_free   (out_free),
      .busy       (busy),
      .res_valid  (res_valid),
      .res_item   (res_item),
      .perm_ctl   (perm_ctl),
      .perm_rdata (perm_rdata),
      .key_we     (key_we),
      .key_waddr  (key_waddr),
      .key_wdata  (key_wdata),
      .key_raddr  (key_raddr),
      .key_rdata  (key_rdata)
   );

   rc4_ram #(
      .WIDTH(8),
      .DEPTH(PERM_SIZE)
   ) u_perm_ram (
      .clock (clock),
      .we    (perm_ctl.we),
      .waddr (perm_ctl.waddr),
      .wdata (perm_ctl.wdata),
      .raddr (perm_ctl.raddr),
      .rdata (perm_rdata)
   );

   rc4_ram #(
      .WIDTH(8),
      .DEPTH(KEY_STORE_DEPTH)
   ) u_key_ram (
      .clock (clock),
      .we    (key_we),
      .waddr (key_waddr),
      .wdata (key_wdata),
      .raddr (key_raddr),
      .rdata (key_rdata)
   );

   // Load a new result, hold a stalled one, drop a taken one
   always_comb begin
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_item_in  = rsp_item_ff;
      if (res_valid) begin
         rsp_valid_in = 1'b1;
         rsp_item_in  = res_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

`default_nettype wire

// File: hw/rtl/rc4_ram.sv
// Generic RAM: one write port, one read port, registered read data.
`default_nettype none

module rc4_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// File: hw/rtl/rc4_core.sv
// Sequencer and datapath: key loading, key schedule and keystream steps.
`default_nettype none

module rc4_core import rc4_pkg::*; #(
   parameter int KEY_STORE_DEPTH = 256
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   input  wire req_item_type                       item,
   input  wire logic                               out_free,
   output logic                                    busy,
   output logic                                    res_valid,
   output rsp_item_type                            res_item,
   output perm_ctl_type                            perm_ctl,
   input  wire logic [7:0]                         perm_rdata,
   output logic                                    key_we,
   output logic [$clog2(KEY_STORE_DEPTH)-1:0]      key_waddr,
   output logic [7:0]                              key_wdata,
   output logic [$clog2(KEY_STORE_DEPTH)-1:0]      key_raddr,
   input  wire logic [7:0]                         key_rdata
);

   localparam int KW = $clog2(KEY_STORE_DEPTH);
   localparam int CW = $clog2(KEY_STORE_DEPTH + 1);

   rc4_state_type      state_ff, state_in;
   req_item_type       item_ff, item_in;
   rsp_item_type       res_ff, res_in;
   logic [CW-1:0]      key_count_ff, key_count_in;
   logic [CW-1:0]      len_ff, len_in;
   logic [KW-1:0]      kidx_ff, kidx_in;
   logic [PERM_AW-1:0] n_ff, n_in;
   logic [7:0]         acc_ff, acc_in;
   logic [7:0]         i_ff, i_in;
   logic [7:0]         j_ff, j_in;
   logic [7:0]         si_ff, si_in;
   logic [7:0]         sj_ff, sj_in;
   logic               keyed_ff, keyed_in;

   logic               store_room;
   logic [CW-1:0]      count_new;
   logic               short_key;
   logic               sweep_end;
   logic [7:0]         acc_sum;

   // Shared decode
   always_comb begin
      store_room = key_count_ff < CW'(KEY_STORE_DEPTH);
      count_new  = key_count_ff + CW'(store_room);
      short_key  = count_new < CW'(MIN_KEY_BYTES);
      sweep_end  = n_ff == PERM_AW'(PERM_SIZE - 1);
      acc_sum    = acc_ff + perm_rdata + key_rdata;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (item.mode == MODE_KEY) begin
                  state_in = ST_KEY;
               end else if (keyed_ff) begin
                  state_in = ST_DT_RD1;
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_KEY: begin
            if (!item_ff.last) begin
               state_in = ST_IDLE;
            end else if (short_key) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_INIT;
            end
         end
         ST_INIT:   state_in = sweep_end ? ST_KS_RD : ST_INIT;
         ST_KS_RD:  state_in = ST_KS_ACC;
         ST_KS_ACC: state_in = ST_KS_SW1;
         ST_KS_SW1: state_in = ST_KS_SW2;
         ST_KS_SW2: state_in = sweep_end ? ST_EMIT : ST_KS_RD;
         ST_DT_RD1: state_in = ST_DT_J;
         ST_DT_J:   state_in = ST_DT_W1;
         ST_DT_W1:  state_in = ST_DT_W2;
         ST_DT_W2:  state_in = ST_DT_RD3;
         ST_DT_RD3: state_in = ST_DT_OUT;
         ST_DT_OUT: state_in = ST_EMIT;
         ST_EMIT:   state_in = out_free ? ST_IDLE : ST_EMIT;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Memory controls and handshake outputs
   always_comb begin
      busy           = state_ff != ST_IDLE;
      res_valid      = 1'b0;
      res_item       = res_ff;
      perm_ctl.we    = 1'b0;
      perm_ctl.waddr = n_ff;
      perm_ctl.wdata = perm_rdata;
      perm_ctl.raddr = n_ff;
      key_we         = 1'b0;
      key_waddr      = key_count_ff[KW-1:0];
      key_wdata      = item_ff.data_byte;
      key_raddr      = kidx_ff;
      unique case (state_ff)
         ST_IDLE: ;
         ST_KEY: begin
            key_we = store_room;
         end
         ST_INIT: begin
            perm_ctl.we    = 1'b1;
            perm_ctl.wdata = n_ff;
         end
         ST_KS_RD: ;
         ST_KS_ACC: begin
            perm_ctl.raddr = acc_sum;
         end
         ST_KS_SW1: begin
            perm_ctl.we = 1'b1;
         end
         ST_KS_SW2: begin
            perm_ctl.we    = 1'b1;
            perm_ctl.waddr = acc_ff;
            perm_ctl.wdata = si_ff;
         end
         ST_DT_RD1: begin
            perm_ctl.raddr = i_ff + 8'd1;
         end
         ST_DT_J: begin
            perm_ctl.raddr = j_ff + perm_rdata;
         end
         ST_DT_W1: begin
            perm_ctl.we    = 1'b1;
            perm_ctl.waddr = i_ff;
         end
         ST_DT_W2: begin
            perm_ctl.we    = 1'b1;
            perm_ctl.waddr = j_ff;
            perm_ctl.wdata = si_ff;
         end
         ST_DT_RD3: begin
            perm_ctl.raddr = si_ff + sj_ff;
         end
         ST_DT_OUT: ;
         ST_EMIT: begin
            res_valid = out_free;
         end
         default: ;
      endcase
   end

   // Datapath register updates
   always_comb begin
      item_in      = item_ff;
      res_in       = res_ff;
      key_count_in = key_count_ff;
      len_in       = len_ff;
      kidx_in      = kidx_ff;
      n_in         = n_ff;
      acc_in       = acc_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      si_in        = si_ff;
      sj_in        = sj_ff;
      keyed_in     = keyed_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               item_in         = item;
               res_in.out_byte = 8'd0;
               res_in.status   = STATUS_NO_KEY;
            end
         end
         ST_KEY: begin
            // Store the byte, then close the key on the last one
            key_count_in    = item_ff.last ? '0 : count_new;
            len_in          = count_new;
            kidx_in         = '0;
            acc_in          = 8'd0;
            n_in            = '0;
            res_in.out_byte = 8'd0;
            res_in.status   = STATUS_SHORT_KEY;
         end
         ST_INIT: begin
            n_in = n_ff + PERM_AW'(1);
         end
         ST_KS_ACC: begin
            acc_in = acc_sum;
            si_in  = perm_rdata;
         end
         ST_KS_SW2: begin
            // Advance the step and wrap the key index at the key length
            n_in    = n_ff + PERM_AW'(1);
            kidx_in = (CW'(kidx_ff) == len_ff - CW'(1)) ? '0 : kidx_ff + KW'(1);
            if (sweep_end) begin
               i_in            = 8'd0;
               j_in            = 8'd0;
               keyed_in        = 1'b1;
               res_in.out_byte = 8'd0;
               res_in.status   = STATUS_OK;
            end
         end
         ST_DT_RD1: begin
            i_in = i_ff + 8'd1;
         end
         ST_DT_J: begin
            si_in = perm_rdata;
            j_in  = j_ff + perm_rdata;
         end
         ST_DT_W1: begin
            sj_in = perm_rdata;
         end
         ST_DT_OUT: begin
            res_in.out_byte = item_ff.data_byte ^ perm_rdata;
            res_in.status   = STATUS_OK;
         end
         default: ;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         key_count_ff <= '0;
         i_ff         <= 8'd0;
         j_ff         <= 8'd0;
         keyed_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         key_count_ff <= key_count_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         keyed_ff     <= keyed_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      item_ff <= item_in;
      res_ff  <= res_in;
      len_ff  <= len_in;
      kidx_ff <= kidx_in;
      n_ff    <= n_in;
      acc_ff  <= acc_in;
      si_ff   <= si_in;
      sj_ff   <= sj_in;
   end

endmodule

`default_nettype wire

// File: hw/rtl/rc4_chk.sv
// Port-level checks for the RC4 stream cipher, bound to the top level.
`default_nettype none

module rc4_chk import rc4_pkg::*; (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_valid,
   input wire logic         req_stall,
   input wire logic         rsp_valid,
   input wire logic         rsp_stall,
   input wire rsp_item_type rsp_item
);

   // A stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
      else $error("stalled result changed");

   // Status items carry a zero byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.status != STATUS_OK |-> rsp_item.out_byte == 8'd0)
      else $error("status item with nonzero byte");

   // Every accepted item raises the stall in the following cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("item accepted in back-to-back cycles");

   // No result straight out of reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind rc4_stream_cipher rc4_chk u_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_item  (rsp_item)
);

`default_nettype wire
